// ===== design/lefm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and compare functions for the log entry filter match core.
// Used by lefm_cell, log_entry_filter_match_core and the testbench; depends on nothing else.
package lefm_pkg;

    localparam int PATTERN_CHARS = 8;
    localparam int WIN_CHARS     = PATTERN_CHARS - 1;
    localparam int PATTERN_W     = 8 * PATTERN_CHARS;
    localparam int LEN_W         = 4;
    localparam int IDX_W         = (PATTERN_CHARS > 1) ? $clog2(PATTERN_CHARS) : 1;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_A     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_A_LEN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_B     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_B_LEN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMBINE_AND   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXCLUDE_MODE  = 3'd5;

    typedef struct packed {
        logic       valid;
        logic [7:0] chr;
    } win_slot_t;

    typedef struct packed {
        logic hit_a;
        logic hit_b;
    } cell_hit_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        r = len;
        if (len > LEN_W'(PATTERN_CHARS))
        begin
            r = LEN_W'(PATTERN_CHARS);
        end
        return r;
    endfunction

    // A slot of a given age agrees with the pattern when the pattern is too short to
    // reach that age, or when the slot holds the pattern byte that lines up with it.
    function automatic logic slot_hit(input logic [PATTERN_W-1:0] pattern,
                                      input logic [LEN_W-1:0]     len,
                                      input logic [LEN_W-1:0]     age,
                                      input win_slot_t            slot);
        logic [LEN_W-1:0] pos;
        logic             r;
        pos = len - age - LEN_W'(1);
        if (age >= len)
        begin
            r = 1'b1;
        end
        else
        begin
            r = slot.valid && (slot.chr == fold_byte(pattern[8*pos[IDX_W-1:0] +: 8]));
        end
        return r;
    endfunction

endpackage

// ===== design/log_entry_filter_match_core.sv =====
`timescale 1ns / 1ps
// Top level of the log entry filter: configuration registers, the window cell chain,
// sticky match flags and the result register. Depends on lefm_pkg and lefm_cell.
//
// The core takes one character per cycle and gives one result request at the end of each
// entry, registered in the cycle after the last character is taken. A new character is taken
// every cycle while the result register is empty or being drained in that same cycle. The
// older characters sit in a row of cells that shift once per accepted character other than
// the last of an entry, which clears them instead; each cell compares its character against
// both patterns in parallel, so the match of a whole pattern is known in the cycle its last
// character arrives. There is no clearing pass after reset.
module log_entry_filter_match_core
    import lefm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             char_in,
    input  logic                   last_of_entry,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   entry_ok,
    output logic                   found_a,
    output logic                   found_b
);

    logic [PATTERN_W-1:0] pattern_a_reg;
    logic [LEN_W-1:0]     pattern_a_len_reg;
    logic [PATTERN_W-1:0] pattern_b_reg;
    logic [LEN_W-1:0]     pattern_b_len_reg;
    logic                 combine_and_reg;
    logic                 exclude_mode_reg;

    logic seen_a_reg;
    logic seen_a_next;
    logic seen_b_reg;
    logic seen_b_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic entry_ok_reg;
    logic found_a_reg;
    logic found_b_reg;

    logic             accept;
    logic             shift;
    logic             clear;
    logic [LEN_W-1:0] len_a;
    logic [LEN_W-1:0] len_b;
    logic             hit_a_now;
    logic             hit_b_now;
    logic             fa;
    logic             fb;
    logic             ok;

    win_slot_t slots [WIN_CHARS:0];
    cell_hit_t hits  [WIN_CHARS:0];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign shift    = accept && !last_of_entry;
    assign clear    = accept && last_of_entry;
    assign len_a    = sat_len(pattern_a_len_reg);
    assign len_b    = sat_len(pattern_b_len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_a_reg     <= '0;
            pattern_a_len_reg <= '0;
            pattern_b_reg     <= '0;
            pattern_b_len_reg <= '0;
            combine_and_reg   <= 1'b0;
            exclude_mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATTERN_A:     pattern_a_reg     <= cfg_wdata[PATTERN_W-1:0];
                CFG_PATTERN_A_LEN: pattern_a_len_reg <= cfg_wdata[LEN_W-1:0];
                CFG_PATTERN_B:     pattern_b_reg     <= cfg_wdata[PATTERN_W-1:0];
                CFG_PATTERN_B_LEN: pattern_b_len_reg <= cfg_wdata[LEN_W-1:0];
                CFG_COMBINE_AND:   combine_and_reg   <= cfg_wdata[0];
                CFG_EXCLUDE_MODE:  exclude_mode_reg  <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // The newest character is compared straight from the input as age zero.
    assign slots[0].valid = 1'b1;
    assign slots[0].chr   = fold_byte(char_in);
    assign hits[0].hit_a  = slot_hit(pattern_a_reg, len_a, '0, slots[0]);
    assign hits[0].hit_b  = slot_hit(pattern_b_reg, len_b, '0, slots[0]);

    for (genvar k = 1; k <= WIN_CHARS; k++)
    begin : g_cell
        lefm_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (shift),
            .clear     (clear),
            .age       (LEN_W'(k)),
            .prev_slot (slots[k-1]),
            .pattern_a (pattern_a_reg),
            .len_a     (len_a),
            .pattern_b (pattern_b_reg),
            .len_b     (len_b),
            .slot      (slots[k]),
            .hit       (hits[k])
        );
    end

    always_comb
    begin
        hit_a_now = (len_a != '0);
        hit_b_now = (len_b != '0);
        for (int k = 0; k <= WIN_CHARS; k++)
        begin
            hit_a_now = hit_a_now && hits[k].hit_a;
            hit_b_now = hit_b_now && hits[k].hit_b;
        end
        seen_a_next = seen_a_reg || hit_a_now;
        seen_b_next = seen_b_reg || hit_b_now;
        fa = seen_a_next || (pattern_a_len_reg == '0);
        fb = seen_b_next || (pattern_b_len_reg == '0);
        ok = combine_and_reg ? (fa && fb) : (fa || fb);
        if (exclude_mode_reg)
        begin
            ok = !ok;
        end
        out_valid_next = out_valid_reg;
        if (clear)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_a_reg    <= 1'b0;
            seen_b_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (clear)
            begin
                seen_a_reg <= 1'b0;
                seen_b_reg <= 1'b0;
            end
            else if (shift)
            begin
                seen_a_reg <= seen_a_next;
                seen_b_reg <= seen_b_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            entry_ok_reg <= ok;
            found_a_reg  <= fa;
            found_b_reg  <= fb;
        end
    end

    assign out_valid = out_valid_reg;
    assign entry_ok  = entry_ok_reg;
    assign found_a   = found_a_reg;
    assign found_b   = found_b_reg;

endmodule

// ===== design/lefm_cell.sv =====
`timescale 1ns / 1ps
// One window cell: holds a folded character of a fixed age and compares it to both patterns.
// Depends on lefm_pkg.
module lefm_cell
    import lefm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  logic                 clear,
    input  logic [LEN_W-1:0]     age,
    input  win_slot_t            prev_slot,
    input  logic [PATTERN_W-1:0] pattern_a,
    input  logic [LEN_W-1:0]     len_a,
    input  logic [PATTERN_W-1:0] pattern_b,
    input  logic [LEN_W-1:0]     len_b,
    output win_slot_t            slot,
    output cell_hit_t            hit
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] chr_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (shift)
        begin
            valid_next = prev_slot.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            chr_reg <= prev_slot.chr;
        end
    end

    assign slot.valid = valid_reg;
    assign slot.chr   = chr_reg;
    assign hit.hit_a  = slot_hit(pattern_a, len_a, age, slot);
    assign hit.hit_b  = slot_hit(pattern_b, len_b, age, slot);

endmodule

// ===== bench/tb_log_entry_filter_match_core.sv =====
`timescale 1ns / 1ps
// Testbench for log_entry_filter_match_core: a short table of directed entries, then
// random entries under changing filter settings, checked against the table's expected
// verdicts or a built-in predictor. Depends on lefm_pkg and the core itself.
module tb_log_entry_filter_match_core;
    import lefm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_CHARS    = 150;
    localparam int DIRECTED_ROWS  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic passed;
        logic found_a;
        logic found_b;
    } verdict_t;

    typedef enum logic {ROW_CFG, ROW_CHAR} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        logic [7:0]             chr;
        logic                   last;
        logic                   typed;
        verdict_t               want;
    } step_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_PATTERN_A;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             char_in = 8'h00;
    logic                   last_of_entry = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   entry_ok;
    logic                   found_a;
    logic                   found_b;

    // Filter settings and per-entry search state as the predictor sees them.
    logic [PATTERN_W-1:0]   filt_pat_a;
    logic [LEN_W-1:0]       filt_len_a;
    logic [PATTERN_W-1:0]   filt_pat_b;
    logic [LEN_W-1:0]       filt_len_b;
    logic                   filt_and;
    logic                   filt_exclude;
    logic [8*WIN_CHARS-1:0] recent_chars;
    int                     recent_count;
    logic                   seen_a;
    logic                   seen_b;

    verdict_t               pending_verdicts[$];
    int                     error_count = 0;
    int                     quiet_cycles = 0;
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;

    step_row_t directed_steps [DIRECTED_ROWS] = '{
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'h78, 1'b1, 1'b1, 3'b111},
        '{ROW_CFG,  CFG_PATTERN_A,     64'h0000_0000_0000_6261, 8'h00, 1'b0, 1'b0, 3'b000},
        '{ROW_CFG,  CFG_PATTERN_A_LEN, 64'd2,                   8'h00, 1'b0, 1'b0, 3'b000},
        '{ROW_CFG,  CFG_PATTERN_B,     64'h00FF_00FF_00FF_00FF, 8'h00, 1'b0, 1'b0, 3'b000},
        '{ROW_CFG,  CFG_PATTERN_B_LEN, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 3'b000},
        '{ROW_CFG,  CFG_SPARE_6,       64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 3'b000},
        '{ROW_CFG,  CFG_SPARE_7,       64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 3'b000},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'h61, 1'b0, 1'b0, 3'b000},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'h41, 1'b0, 1'b0, 3'b000},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'h42, 1'b1, 1'b1, 3'b110},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'hFF, 1'b0, 1'b0, 3'b000},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'h00, 1'b0, 1'b0, 3'b000},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'hFF, 1'b0, 1'b0, 3'b000},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'h00, 1'b0, 1'b0, 3'b000},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'hFF, 1'b0, 1'b0, 3'b000},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'h00, 1'b0, 1'b0, 3'b000},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'hFF, 1'b0, 1'b0, 3'b000},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'h00, 1'b1, 1'b1, 3'b101},
        '{ROW_CFG,  CFG_COMBINE_AND,   64'd1,                   8'h00, 1'b0, 1'b0, 3'b000},
        '{ROW_CFG,  CFG_EXCLUDE_MODE,  64'd1,                   8'h00, 1'b0, 1'b0, 3'b000},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'h41, 1'b0, 1'b0, 3'b000},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'h62, 1'b1, 1'b1, 3'b110},
        '{ROW_CFG,  CFG_PATTERN_A,     64'h0000_0000_0000_5B40, 8'h00, 1'b0, 1'b0, 3'b000},
        '{ROW_CFG,  CFG_PATTERN_B_LEN, 64'd1,                   8'h00, 1'b0, 1'b0, 3'b000},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'h60, 1'b0, 1'b0, 3'b000},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'h7B, 1'b0, 1'b0, 3'b000},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'hFF, 1'b1, 1'b1, 3'b101},
        '{ROW_CFG,  CFG_COMBINE_AND,   64'd0,                   8'h00, 1'b0, 1'b0, 3'b000},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'h5A, 1'b0, 1'b0, 3'b000},
        '{ROW_CFG,  CFG_PATTERN_A_LEN, 64'd0,                   8'h00, 1'b0, 1'b0, 3'b000},
        '{ROW_CHAR, CFG_PATTERN_A,     64'h0,                   8'h71, 1'b1, 1'b0, 3'b000},
        '{ROW_CFG,  CFG_EXCLUDE_MODE,  64'd0,                   8'h00, 1'b0, 1'b0, 3'b000}
    };

    log_entry_filter_match_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_in       (char_in),
        .last_of_entry (last_of_entry),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .entry_ok      (entry_ok),
        .found_a       (found_a),
        .found_b       (found_b)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            u = c - 8'h20;
        end
        return u;
    endfunction

    function automatic int clamp_len(input logic [LEN_W-1:0] len);
        return (int'(len) > PATTERN_CHARS) ? PATTERN_CHARS : int'(len);
    endfunction

    // True when the pattern ends at the newest character; recent holds that character
    // in its lowest byte and older ones above it.
    function automatic logic ends_with_pattern(input logic [PATTERN_W-1:0] pat,
                                               input logic [LEN_W-1:0]     len,
                                               input logic [63:0]          recent,
                                               input int                   avail);
        int n;
        n = clamp_len(len);
        if (n == 0 || n > avail)
        begin
            return 1'b0;
        end
        for (int k = 0; k < n; k++)
        begin
            if (to_upper(pat[8*k +: 8]) != recent[8*(n-1-k) +: 8])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] swap_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && $urandom_range(1))
        begin
            r = c ^ 8'h20;
        end
        return r;
    endfunction

    // Mostly a small set of letters in either case, so that patterns and text meet often.
    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        if ($urandom_range(9) < 6)
        begin
            c = swap_case(8'h41 + 8'($urandom_range(3)));
        end
        else
        begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    task automatic track_char(input logic [7:0] c, input logic last,
                              input logic typed, input verdict_t want);
        logic [63:0] recent;
        verdict_t    v;
        recent = {recent_chars, to_upper(c)};
        if (ends_with_pattern(filt_pat_a, filt_len_a, recent, recent_count + 1))
        begin
            seen_a = 1'b1;
        end
        if (ends_with_pattern(filt_pat_b, filt_len_b, recent, recent_count + 1))
        begin
            seen_b = 1'b1;
        end
        if (!last)
        begin
            recent_chars = recent[8*WIN_CHARS-1:0];
            if (recent_count < WIN_CHARS)
            begin
                recent_count++;
            end
        end
        else
        begin
            v.found_a = seen_a || (filt_len_a == '0);
            v.found_b = seen_b || (filt_len_b == '0);
            v.passed  = filt_and ? (v.found_a && v.found_b) : (v.found_a || v.found_b);
            if (filt_exclude)
            begin
                v.passed = !v.passed;
            end
            pending_verdicts.push_back(typed ? want : v);
            recent_chars = '0;
            recent_count = 0;
            seen_a = 1'b0;
            seen_b = 1'b0;
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic last,
                             input logic typed, input verdict_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        char_in       <= c;
        last_of_entry <= last;
        @(negedge clk);
        while (in_ready !== 1'b1)
        begin
            @(negedge clk);
        end
        track_char(c, last, typed, want);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_PATTERN_A:     filt_pat_a   = val;
            CFG_PATTERN_A_LEN: filt_len_a   = val[LEN_W-1:0];
            CFG_PATTERN_B:     filt_pat_b   = val;
            CFG_PATTERN_B_LEN: filt_len_b   = val[LEN_W-1:0];
            CFG_COMBINE_AND:   filt_and     = val[0];
            CFG_EXCLUDE_MODE:  filt_exclude = val[0];
            default:           ;
        endcase
        @(posedge clk);
    endtask

    task automatic pick_filter();
        logic [CFG_DATA_W-1:0] val;
        int                    r;
        for (int i = 0; i < 6; i++)
        begin
            val = {$urandom(), $urandom()};
            case (logic'(CFG_INDEX_W'(i) == CFG_PATTERN_A || CFG_INDEX_W'(i) == CFG_PATTERN_B))
                1'b1:
                begin
                    for (int k = 0; k < PATTERN_CHARS; k++)
                    begin
                        val[8*k +: 8] = text_byte();
                    end
                end
                default:
                begin
                    r = $urandom_range(15);
                    if (r < 2)
                    begin
                        val[LEN_W-1:0] = '0;
                    end
                    else if (r < 4)
                    begin
                        val[LEN_W-1:0] = LEN_W'(PATTERN_CHARS);
                    end
                    else if (r == 4)
                    begin
                        val[LEN_W-1:0] = LEN_W'($urandom_range(15, PATTERN_CHARS + 1));
                    end
                    else
                    begin
                        val[LEN_W-1:0] = LEN_W'($urandom_range(4, 1));
                    end
                end
            endcase
            write_reg(CFG_INDEX_W'(i), val);
        end
        if ($urandom_range(3) == 0)
        begin
            write_reg($urandom_range(1) ? CFG_SPARE_6 : CFG_SPARE_7, {$urandom(), $urandom()});
        end
    endtask

    // One entry: random text around a copy of a pattern in mixed case, a copy cut short
    // by one character, or nothing at all.
    task automatic send_entry(output int sent);
        logic [7:0] text[$];
        int         n;
        int         pre;
        int         plen;
        int         pick;
        logic [PATTERN_W-1:0] pat;
        n    = ($urandom_range(9) == 0) ? $urandom_range(24, 13) : $urandom_range(10, 1);
        pre  = $urandom_range(n);
        pick = $urandom_range(9);
        pat  = (pick < 4 || pick == 7) ? filt_pat_a : filt_pat_b;
        plen = (pick < 4 || pick == 7) ? clamp_len(filt_len_a) : clamp_len(filt_len_b);
        if (pick == 7 && plen > 0)
        begin
            plen--;
        end
        else if (pick > 7)
        begin
            plen = 0;
        end
        for (int i = 0; i < pre; i++)
        begin
            text.push_back(text_byte());
        end
        for (int k = 0; k < plen; k++)
        begin
            text.push_back(swap_case(pat[8*k +: 8]));
        end
        for (int i = pre; i < n; i++)
        begin
            text.push_back(text_byte());
        end
        for (int i = 0; i < text.size(); i++)
        begin
            send_char(text[i], i == text.size() - 1, 1'b0, '0);
        end
        sent = text.size();
    endtask

    always @(negedge clk)
    begin
        verdict_t got;
        verdict_t want;
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (out_valid && out_ready)
        begin
            got = '{passed: entry_ok, found_a: found_a, found_b: found_b};
            if (pending_verdicts.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("unexpected result: ok=%0b a=%0b b=%0b", got.passed,
                             got.found_a, got.found_b);
                end
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("mismatch: expected ok=%0b a=%0b b=%0b, got ok=%0b a=%0b b=%0b",
                                 want.passed, want.found_a, want.found_b,
                                 got.passed, got.found_a, got.found_b);
                    end
                end
            end
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int send_pcts [3];
        int recv_pcts [3];
        int chars_sent;
        int sent;
        send_pcts = '{32, 64, 0};
        recv_pcts = '{64, 32, 0};
        filt_pat_a   = '0;
        filt_len_a   = '0;
        filt_pat_b   = '0;
        filt_len_b   = '0;
        filt_and     = 1'b0;
        filt_exclude = 1'b0;
        recent_chars = '0;
        recent_count = 0;
        seen_a       = 1'b0;
        seen_b       = 1'b0;
        send_idle_pct = send_pcts[0];
        recv_idle_pct = recv_pcts[0];

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(directed_steps[i].reg_index, directed_steps[i].reg_value);
            end
            else
            begin
                send_char(directed_steps[i].chr, directed_steps[i].last,
                          directed_steps[i].typed, directed_steps[i].want);
            end
        end

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = send_pcts[mode];
            recv_idle_pct = recv_pcts[mode];
            for (int phase = 0; phase < 4; phase++)
            begin
                wait_drained();
                pick_filter();
                chars_sent = 0;
                while (chars_sent < PHASE_CHARS)
                begin
                    if ($urandom_range(39) == 0)
                    begin
                        wait_drained();
                    end
                    send_entry(sent);
                    chars_sent += sent;
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (error_count == 0 && pending_verdicts.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
